/* src/adler_pkg.sv */
package adler_pkg;

  // Stream bytes carried by one input beat, and the size of each half word.
  localparam int BYTES_PER_ITEM = 16;
  localparam int HALF_BYTES     = BYTES_PER_ITEM / 2;

  // Adler-32 modulus, and the remainder of 2^16 modulo it (65536 - 65521).
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [4:0]  FOLD      = 5'd15;

  // Per-beat byte sums handed from the prep pipeline to the accumulator.
  // byte_sum is the plain sum of the valid bytes; weight_sum is the sum of
  // each byte times the number of valid bytes from it to the end of the beat.
  typedef struct packed {
    logic [11:0] byte_sum;
    logic [15:0] weight_sum;
    logic [4:0]  count;
    logic        first;
    logic        last;
  } prep_beat_t;

  // Reduce a value below twice the modulus with one compare and subtract.
  function automatic logic [15:0] mod_reduce(input logic [16:0] value);
    logic [16:0] diff;
    begin
      diff = value - ADLER_MOD;
      mod_reduce = (value >= ADLER_MOD) ? diff[15:0] : value[15:0];
    end
  endfunction

endpackage

/* src/adler_prep.sv */
module adler_prep (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [63:0]             bytes_low,
  input  logic [63:0]             bytes_high,
  input  logic [4:0]              valid_count,
  input  logic                    first,
  input  logic                    last,
  input  logic                    item_valid,
  output logic                    item_stall,
  output adler_pkg::prep_beat_t   beat,
  output logic                    beat_valid,
  input  logic                    beat_take
);

  // Input register.
  logic         s0_valid;
  logic [127:0] s0_bytes;
  logic [4:0]   s0_count;
  logic         s0_first;
  logic         s0_last;

  // Half-beat sums register.
  logic         s1_valid;
  logic [10:0]  s1_sum_a;
  logic [10:0]  s1_sum_b;
  logic [14:0]  s1_wsum_a;
  logic [14:0]  s1_wsum_b;
  logic [4:0]   s1_count;
  logic         s1_first;
  logic         s1_last;

  logic [4:0]   count_sat;
  logic [10:0]  sum_a;
  logic [10:0]  sum_b;
  logic [14:0]  wsum_a;
  logic [14:0]  wsum_b;
  logic [11:0]  byte_sum;
  logic [15:0]  weight_total;
  logic [16:0]  scaled;
  logic [16:0]  weight_diff;
  logic         free0;
  logic         free1;
  logic         free2;

  // Each stage moves on when the stage after it is empty or moving.
  assign free2      = !beat_valid || beat_take;
  assign free1      = !s1_valid || free2;
  assign free0      = !s0_valid || free1;
  assign item_stall = !free0;

  // Counts above the beat width are clamped.
  assign count_sat = (valid_count > 5'(adler_pkg::BYTES_PER_ITEM)) ?
                     5'(adler_pkg::BYTES_PER_ITEM) : valid_count;

  // Masked byte sums and position-weighted sums, one half of the beat each.
  always_comb begin
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    sum_a  = '0;
    sum_b  = '0;
    wsum_a = '0;
    wsum_b = '0;
    for (int i = 0; i < adler_pkg::HALF_BYTES; i++) begin
      byte_a = (5'(i) < s0_count) ? s0_bytes[8*i +: 8] : 8'd0;
      byte_b = (5'(i + adler_pkg::HALF_BYTES) < s0_count) ?
               s0_bytes[8*(i + adler_pkg::HALF_BYTES) +: 8] : 8'd0;
      sum_a  = sum_a + 11'(byte_a);
      sum_b  = sum_b + 11'(byte_b);
      wsum_a = wsum_a + 15'(byte_a) * 15'(i);
      wsum_b = wsum_b + 15'(byte_b) * 15'(i + adler_pkg::HALF_BYTES);
    end
  end

  // Sum of (count - i) * byte_i equals count * sum(byte_i) - sum(i * byte_i).
  assign byte_sum     = 12'(s1_sum_a) + 12'(s1_sum_b);
  assign weight_total = 16'(s1_wsum_a) + 16'(s1_wsum_b);
  assign scaled       = 17'(s1_count) * 17'(byte_sum);
  assign weight_diff  = scaled - 17'(weight_total);

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      if (free0) begin
        s0_valid <= item_valid;
      end
      if (free1) begin
        s1_valid <= s0_valid;
      end
      if (free2) begin
        beat_valid <= s1_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (free0) begin
      s0_bytes <= {bytes_high, bytes_low};
      s0_count <= count_sat;
      s0_first <= first;
      s0_last  <= last;
    end
    if (free1) begin
      s1_sum_a  <= sum_a;
      s1_sum_b  <= sum_b;
      s1_wsum_a <= wsum_a;
      s1_wsum_b <= wsum_b;
      s1_count  <= s0_count;
      s1_first  <= s0_first;
      s1_last   <= s0_last;
    end
    if (free2) begin
      beat.byte_sum   <= byte_sum;
      beat.weight_sum <= weight_diff[15:0];
      beat.count      <= s1_count;
      beat.first      <= s1_first;
      beat.last       <= s1_last;
    end
  end

endmodule

/* src/adler_accum.sv */
module adler_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  adler_pkg::prep_beat_t   beat,
  input  logic                    beat_valid,
  output logic                    beat_take,
  input  logic [15:0]             start_low,
  input  logic [15:0]             start_high,
  output logic [31:0]             checksum,
  output logic                    result_valid,
  input  logic                    result_stall
);

  logic [15:0] low_sum;
  logic [15:0] high_sum;
  logic [15:0] low_base;
  logic [15:0] high_base;
  logic [16:0] low_raw;
  logic [15:0] low_sum_next;
  logic [20:0] scaled;
  logic [20:0] high_raw;
  logic [16:0] folded;
  logic [15:0] high_sum_next;
  logic        out_free;

  // A beat that ends a message waits until the result register can take it.
  assign out_free  = !result_valid || !result_stall;
  assign beat_take = beat_valid && (!beat.last || out_free);

  // Start of message reloads both sums from the configured value.
  assign low_base  = beat.first ? start_low  : low_sum;
  assign high_base = beat.first ? start_high : high_sum;

  // Low sum: one add of the beat's byte total, then one reduction.
  assign low_raw      = 17'(low_base) + 17'(beat.byte_sum);
  assign low_sum_next = adler_pkg::mod_reduce(low_raw);

  // High sum gains count * low_base plus the weighted byte sum. The upper
  // bits are folded back using 2^16 = 15 modulo 65521, then one reduction.
  assign scaled        = 21'(beat.count) * 21'(low_base);
  assign high_raw      = 21'(high_base) + scaled + 21'(beat.weight_sum);
  assign folded        = 17'(high_raw[15:0]) + 17'(high_raw[20:16]) * 17'(adler_pkg::FOLD);
  assign high_sum_next = adler_pkg::mod_reduce(folded);

  // Running sums and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum      <= 16'd1;
      high_sum     <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (beat_take) begin
        low_sum  <= low_sum_next;
        high_sum <= high_sum_next;
      end
      if (beat_take && beat.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (beat_take && beat.last) begin
      checksum <= {high_sum_next, low_sum_next};
    end
  end

endmodule

/* src/adler32_checksum.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------------------
// item     | item_valid / item_stall    | bytes_low, bytes_high, valid_count,
//          |                            | first, last
// result   | result_valid / result_stall| checksum
// cfg      | cfg_valid / cfg_ready      | start_value
//
// One beat of up to 16 bytes is accepted every cycle while item_stall is low;
// a last beat's checksum is registered after the s0, s1 and beat registers.
// Three prep stages form the byte sums; the accumulator closes the 16-bit
// sum loop with no register inside it, which sets the one-beat-per-cycle rate.
// Synchronous reset loads start value 1 and the sums 1 and 0.
// A stalled result holds only beats that end a message; other beats keep
// flowing behind it until one more last beat reaches the accumulator.
module adler32_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [63:0] bytes_low,
  input  logic [63:0] bytes_high,
  input  logic [4:0]  valid_count,
  input  logic        first,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] checksum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] start_value
);

  logic [15:0]           start_low;
  logic [15:0]           start_high;
  adler_pkg::prep_beat_t beat;
  logic                  beat_valid;
  logic                  beat_take;

  // Configuration is always taken; both halves are stored already reduced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low  <= 16'd1;
      start_high <= 16'd0;
    end else if (cfg_valid) begin
      start_low  <= adler_pkg::mod_reduce({1'b0, start_value[15:0]});
      start_high <= adler_pkg::mod_reduce({1'b0, start_value[31:16]});
    end
  end

  // Byte sum pipeline.
  adler_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .bytes_low   (bytes_low),
    .bytes_high  (bytes_high),
    .valid_count (valid_count),
    .first       (first),
    .last        (last),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .beat        (beat),
    .beat_valid  (beat_valid),
    .beat_take   (beat_take)
  );

  // Running sums and result register.
  adler_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .beat_valid   (beat_valid),
    .beat_take    (beat_take),
    .start_low    (start_low),
    .start_high   (start_high),
    .checksum     (checksum),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

/* test/adler32_checksum_tb.sv */
module adler32_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 12;
  localparam int TAIL_CYCLES    = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS    = 280;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [63:0] bytes_low = '0;
  logic [63:0] bytes_high = '0;
  logic [4:0]  valid_count = '0;
  logic        first = 1'b0;
  logic        last = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] checksum;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] start_value = '0;

  // Predicted sums and the start value the block should hold.
  logic [15:0] sum_low = 16'd1;
  logic [15:0] sum_high = 16'd0;
  logic [31:0] cfg_start = 32'd1;
  logic [31:0] pending_sums[$];
  logic [31:0] want_sum;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int beats_sent = 0;
  int sums_checked = 0;
  int cfg_writes = 0;

  adler32_checksum i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .bytes_low    (bytes_low),
    .bytes_high   (bytes_high),
    .valid_count  (valid_count),
    .first        (first),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .checksum     (checksum),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .start_value  (start_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Fold one accepted beat into the predicted sums; queue the checksum on last.
  function automatic void absorb_beat(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [4:0] cnt, input logic f, input logic l);
    logic [127:0] data;
    int unsigned  n;
    int unsigned  a;
    int unsigned  b;
    int unsigned  modulus;
    int           i;
    data = {hi, lo};
    modulus = 32'(adler_pkg::ADLER_MOD);
    n = (cnt > adler_pkg::BYTES_PER_ITEM) ? adler_pkg::BYTES_PER_ITEM : 32'(cnt);
    if (f) begin
      a = 32'(cfg_start[15:0]) % modulus;
      b = 32'(cfg_start[31:16]) % modulus;
    end else begin
      a = 32'(sum_low);
      b = 32'(sum_high);
    end
    for (i = 0; i < n; i++) begin
      a = (a + 32'(data[i*8 +: 8])) % modulus;
      b = (b + a) % modulus;
    end
    sum_low = a[15:0];
    sum_high = b[15:0];
    if (l) pending_sums.push_back({sum_high, sum_low});
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) rand_word = '1;
    else if (r < 12) rand_word = '0;
    else rand_word = {$urandom, $urandom};
  endfunction

  // Mostly legal counts, with some zero and some oversized ones.
  function automatic logic [4:0] rand_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) rand_count = 5'($urandom_range(16, 1));
    else if (r < 80) rand_count = 5'd16;
    else if (r < 88) rand_count = 5'd0;
    else rand_count = 5'($urandom_range(31, 17));
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_beat(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] cnt, input logic f, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    bytes_low   <= lo;
    bytes_high  <= hi;
    valid_count <= cnt;
    first       <= f;
    last        <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    absorb_beat(lo, hi, cnt, f, l);
    beats_sent++;
  endtask

  task automatic send_message(input int n_beats);
    int k;
    for (k = 0; k < n_beats; k++)
      send_beat(rand_word(), rand_word(), rand_count(), k == 0, k == n_beats - 1);
  endtask

  // Stop offering beats, let every expected checksum arrive, then let the
  // pipeline empty out.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] value);
    wait_idle();
    cfg_valid   <= 1'b1;
    start_value <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_start = value;
    cfg_writes++;
  endtask

  // Sums right after reset, zero and oversized counts, all-ones bytes.
  task automatic test_reset_state();
    send_beat('0, '0, 5'd16, 1'b0, 1'b1);
    send_beat('1, '1, 5'd0, 1'b1, 1'b1);
    send_beat('1, '1, 5'd16, 1'b1, 1'b0);
    send_beat('1, '1, 5'd31, 1'b0, 1'b1);
    send_beat(64'h0807_0605_0403_0201, 64'hffee_ddcc_bbaa_0a09, 5'd17, 1'b1, 1'b1);
    send_beat({32{2'b10}}, {32{2'b01}}, 5'd1, 1'b1, 1'b1);
    send_beat({32{2'b01}}, {32{2'b10}}, 5'd16, 1'b1, 1'b1);
  endtask

  // Start values at the extremes and with halves above the modulus.
  task automatic test_start_values();
    logic [31:0] starts[5];
    int          k;
    starts = '{32'h0000_0000, 32'hffff_ffff, 32'hfff1_fff1, 32'hfff0_fff0, 32'h8000_7fff};
    for (k = 0; k < 5; k++) begin
      write_start(starts[k]);
      send_beat(rand_word(), rand_word(), 5'd16, 1'b1, 1'b1);
    end
    // A reload in the middle of a message, then a message that carries on
    // from the previous checksum without a first beat.
    send_beat('1, '1, 5'd8, 1'b1, 1'b0);
    send_beat(rand_word(), rand_word(), 5'd5, 1'b1, 1'b0);
    send_beat('1, '1, 5'd16, 1'b0, 1'b1);
    send_beat(rand_word(), rand_word(), 5'd3, 1'b0, 1'b1);
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    hold_asks <= hold_asks + 1;
    for (k = 0; k < 48; k++)
      send_beat(rand_word(), rand_word(), rand_count(), 1'b1, (k % 3) != 1);
    wait_idle();
  endtask

  // Mostly well-formed messages, with stray beats carrying random flags.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [31:0] start);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_start(start);
    goal = beats_sent + PHASE_BEATS;
    while (beats_sent < goal) begin
      if ($urandom_range(99) < 85)
        send_message($urandom_range(6, 1));
      else
        send_beat(rand_word(), rand_word(), rand_count(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_start_values();
    test_backpressure();
    test_random_traffic(26, 47, $urandom);
    test_random_traffic(47, 26, $urandom);
    test_random_traffic(0, 0, 32'd1);
    wait_idle();
    $display("Sent %0d beats over %0d start values, checked %0d checksums.",
             beats_sent, cfg_writes, sums_checked);
    $display("Included zero and oversized counts, mid-message reloads and a long result hold.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted checksum with the oldest one predicted.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: checksum beat with none expected, got %h", $time, checksum);
        errors++;
      end else begin
        want_sum = pending_sums.pop_front();
        sums_checked++;
        if (checksum !== want_sum) begin
          $display("%0t: checksum mismatch, expected %h, got %h", $time, want_sum, checksum);
          errors++;
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
